/* sv/xbr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package xbr_pkg;

  localparam int WordW = 64;
  localparam int HalfW = WordW / 2;
  localparam int OpW = 2;
  localparam int BoundW = 32;
  localparam int SpanW = BoundW + 1;
  localparam int ProbW = 54;
  localparam int FracW = ProbW - 1;
  localparam int BitCntW = $clog2(WordW);

  localparam logic [WordW-1:0] GoldenStep = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [WordW-1:0] MixOne = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [WordW-1:0] MixTwo = 64'h94D0_49BB_1331_11EB;
  localparam logic [WordW-1:0] NonzeroFill = 64'h853C_49E6_748F_EA9B;

  localparam int MixShA = 30;
  localparam int MixShB = 27;
  localparam int MixShC = 31;
  localparam int RotA = 55;
  localparam int ShlB = 14;
  localparam int RotC = 36;

  typedef enum logic [OpW-1:0] {
    OP_RESEED  = 2'd0,
    OP_RAW     = 2'd1,
    OP_UNIFORM = 2'd2,
    OP_CHANCE  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED_ADD,
    ST_MIX_A,
    ST_MUL1,
    ST_MUL2,
    ST_RAW,
    ST_CHANCE,
    ST_UNI_DRAW,
    ST_UNI_REM,
    ST_UNI_CHECK,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [WordW-1:0] w0;
    logic [WordW-1:0] w1;
  } words_t;

  // One xoroshiro128+ state advance.
  function automatic words_t xbr_step(input logic [WordW-1:0] a,
                                      input logic [WordW-1:0] b_in);
    logic [WordW-1:0] b;
    words_t r;
    b = b_in ^ a;
    r.w0 = ((a << RotA) | (a >> (WordW - RotA))) ^ b ^ (b << ShlB);
    r.w1 = (b << RotC) | (b >> (WordW - RotC));
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/xbr_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface xbr_req_if import xbr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OpW-1:0]           operation;
  logic [WordW-1:0]         seed;
  logic signed [BoundW-1:0] range_min;
  logic signed [BoundW-1:0] range_max;
  logic [ProbW-1:0]         probability;

  modport source (output valid, operation, seed, range_min, range_max, probability,
                  input ready);
  modport sink (input valid, operation, seed, range_min, range_max, probability,
                output ready);
endinterface

interface xbr_rsp_if import xbr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [WordW-1:0]         raw_word;
  logic signed [BoundW-1:0] ranged_value;
  logic                     hit;

  modport source (output valid, raw_word, ranged_value, hit, input ready);
  modport sink (input valid, raw_word, ranged_value, hit, output ready);
endinterface

`default_nettype wire

/* sv/xbr_mul.sv */
`timescale 1ns / 1ps
`default_nettype none

// Low 64 bits of a 64 by 64 product, built from three 32 by 32 partial
// products on one shared multiplier. The result is valid while done_o is high.
module xbr_mul import xbr_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [WordW-1:0] a_i,
  input  wire logic [WordW-1:0] b_i,
  output logic                  done_o,
  output logic [WordW-1:0]      prod_o
);

  localparam logic [1:0] StepLl = 2'd0;
  localparam logic [1:0] StepLh = 2'd1;
  localparam logic [1:0] StepHl = 2'd2;
  localparam logic [1:0] StepEnd = 2'd3;

  logic             busy_q;
  logic [1:0]       step_q;
  logic             done_q;
  logic [WordW-1:0] a_q, b_q;
  logic [WordW-1:0] part_q;
  logic [WordW-1:0] acc_q;
  logic [HalfW-1:0] op_x, op_y;
  logic [WordW-1:0] mul_w;

  always_comb begin
    case (step_q)
      StepLl: begin
        op_x = a_q[HalfW-1:0];
        op_y = b_q[HalfW-1:0];
      end
      StepLh: begin
        op_x = a_q[HalfW-1:0];
        op_y = b_q[WordW-1:HalfW];
      end
      default: begin
        op_x = a_q[WordW-1:HalfW];
        op_y = b_q[HalfW-1:0];
      end
    endcase
    mul_w = WordW'(op_x) * WordW'(op_y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= StepLl;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (step_q == StepEnd);
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= StepLl;
      end else if (busy_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == StepEnd) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // The cross products only reach the upper half of the low word.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end
    if (busy_q) begin
      part_q <= mul_w;
      case (step_q)
        StepLh: acc_q <= part_q;
        StepHl, StepEnd: acc_q[WordW-1:HalfW] <= acc_q[WordW-1:HalfW] + part_q[HalfW-1:0];
        default: ;
      endcase
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

`default_nettype wire

/* sv/xbr_rem.sv */
`timescale 1ns / 1ps
`default_nettype none

// Radix-2 restoring remainder of a 64-bit word by a span of up to 2^32,
// one dividend bit per cycle. The result is valid while done_o is high.
module xbr_rem import xbr_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [WordW-1:0] dividend_i,
  input  wire logic [SpanW-1:0] divisor_i,
  output logic                  done_o,
  output logic [SpanW-1:0]      rem_o
);

  logic               busy_q;
  logic               done_q;
  logic [BitCntW-1:0] cnt_q;
  logic [WordW-1:0]   dvd_q;
  logic [SpanW-1:0]   dvs_q;
  logic [SpanW-1:0]   rem_q;
  logic [SpanW:0]     trial;
  logic [SpanW:0]     diff;
  logic [SpanW-1:0]   rem_d;

  always_comb begin
    trial = {rem_q, dvd_q[WordW-1]};
    diff = trial - {1'b0, dvs_q};
    if (trial >= {1'b0, dvs_q}) begin
      rem_d = diff[SpanW-1:0];
    end else begin
      rem_d = trial[SpanW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '1);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == '1) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << 1;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o = rem_q;

endmodule

`default_nettype wire

/* sv/xoroshiro_bounded_random.sv */
// Raw and chance items pass through their draw state and then the emit state; chance
// items that need no draw and empty uniform ranges go straight to the emit state.
// Uniform items draw, wait on the 64-step remainder unit, check the draw and then
// emit; each rejected draw (under one chance in 2^32) starts another draw and remainder.
// Reseed keeps the block busy for two mixes, each two 4-step passes
// of the shared 32x32 multiplier. One item is in work at a time.
`timescale 1ns / 1ps
`default_nettype none

module xoroshiro_bounded_random import xbr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  xbr_req_if.sink   req_i,
  xbr_rsp_if.source rsp_o
);

  state_e state_q, state_d;
  logic             widx_q, widx_d;
  logic [WordW-1:0] seed_q, seed_d;
  logic [WordW-1:0] w0_q, w0_d, w1_q, w1_d;
  logic [WordW-1:0] z_q, z_d;
  logic [BoundW-1:0] min_q, min_d;
  logic [SpanW-1:0] span_q, span_d;
  logic [FracW-1:0] prob_q, prob_d;
  logic [WordW-1:0] draw_q, draw_d;
  logic [WordW-1:0] base_q, base_d;
  logic [BoundW-1:0] remv_q, remv_d;
  logic [WordW-1:0] res_raw_q, res_raw_d;
  logic [BoundW-1:0] res_val_q, res_val_d;
  logic             res_hit_q, res_hit_d;

  logic             out_valid_q;
  logic [WordW-1:0] out_raw_q;
  logic [BoundW-1:0] out_val_q;
  logic             out_hit_q;
  logic             load_out;

  logic             mul_start, mul_done;
  logic [WordW-1:0] mul_a, mul_b, mul_prod;
  logic             rem_start, rem_done;
  logic [SpanW-1:0] rem_val;

  words_t           nxt;
  logic [WordW-1:0] draw_sum;
  logic [WordW-1:0] mixed;
  logic [WordW:0]   bound_sum;
  logic [SpanW-1:0] span_in;

  assign nxt = xbr_step(w0_q, w1_q);
  assign draw_sum = w0_q + w1_q;
  assign span_in = {req_i.range_max[BoundW-1], req_i.range_max}
                 - {req_i.range_min[BoundW-1], req_i.range_min} + SpanW'(1);
  // A draw is rejected when its block of span values reaches 2^64 (base plus span carries out).
  assign bound_sum = {1'b0, base_q} + {{(WordW + 1 - SpanW){1'b0}}, span_q};

  assign req_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    widx_d = widx_q;
    seed_d = seed_q;
    w0_d = w0_q;
    w1_d = w1_q;
    z_d = z_q;
    min_d = min_q;
    span_d = span_q;
    prob_d = prob_q;
    draw_d = draw_q;
    base_d = base_q;
    remv_d = remv_q;
    res_raw_d = res_raw_q;
    res_val_d = res_val_q;
    res_hit_d = res_hit_q;
    mul_start = 1'b0;
    mul_a = z_q;
    mul_b = MixOne;
    rem_start = 1'b0;
    load_out = 1'b0;
    mixed = mul_prod ^ (mul_prod >> MixShC);

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          res_raw_d = '0;
          res_val_d = '0;
          res_hit_d = 1'b0;
          min_d = req_i.range_min;
          span_d = span_in;
          prob_d = req_i.probability[FracW-1:0];
          case (op_e'(req_i.operation))
            OP_RESEED: begin
              seed_d = req_i.seed;
              widx_d = 1'b0;
              state_d = ST_SEED_ADD;
            end
            OP_RAW: state_d = ST_RAW;
            OP_UNIFORM: begin
              if (req_i.range_max > req_i.range_min) begin
                state_d = ST_UNI_DRAW;
              end else begin
                res_val_d = req_i.range_min;
                state_d = ST_EMIT;
              end
            end
            default: begin
              // Probability zero or one and above needs no draw.
              if (req_i.probability[ProbW-1]) begin
                res_hit_d = 1'b1;
                state_d = ST_EMIT;
              end else if (req_i.probability == '0) begin
                state_d = ST_EMIT;
              end else begin
                state_d = ST_CHANCE;
              end
            end
          endcase
        end
      end
      ST_SEED_ADD: begin
        seed_d = seed_q + GoldenStep;
        z_d = seed_q + GoldenStep;
        state_d = ST_MIX_A;
      end
      ST_MIX_A: begin
        mul_start = 1'b1;
        mul_a = z_q ^ (z_q >> MixShA);
        mul_b = MixOne;
        state_d = ST_MUL1;
      end
      ST_MUL1: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a = mul_prod ^ (mul_prod >> MixShB);
          mul_b = MixTwo;
          state_d = ST_MUL2;
        end
      end
      ST_MUL2: begin
        if (mul_done) begin
          if (!widx_q) begin
            w0_d = mixed;
            widx_d = 1'b1;
            state_d = ST_SEED_ADD;
          end else begin
            w1_d = mixed;
            widx_d = 1'b0;
            if (w0_q == '0 && mixed == '0) begin
              w0_d = NonzeroFill;
            end
            state_d = ST_IDLE;
          end
        end
      end
      ST_RAW: begin
        res_raw_d = draw_sum;
        w0_d = nxt.w0;
        w1_d = nxt.w1;
        state_d = ST_EMIT;
      end
      ST_CHANCE: begin
        res_hit_d = (draw_sum[WordW-1:WordW-FracW] < prob_q);
        w0_d = nxt.w0;
        w1_d = nxt.w1;
        state_d = ST_EMIT;
      end
      ST_UNI_DRAW: begin
        draw_d = draw_sum;
        w0_d = nxt.w0;
        w1_d = nxt.w1;
        rem_start = 1'b1;
        state_d = ST_UNI_REM;
      end
      ST_UNI_REM: begin
        if (rem_done) begin
          base_d = draw_q - WordW'(rem_val[BoundW-1:0]);
          remv_d = rem_val[BoundW-1:0];
          state_d = ST_UNI_CHECK;
        end
      end
      ST_UNI_CHECK: begin
        if (bound_sum[WordW]) begin
          state_d = ST_UNI_DRAW;
        end else begin
          res_val_d = min_q + remv_q;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || rsp_o.ready) begin
          load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SEED_ADD;
      widx_q <= 1'b0;
      seed_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      widx_q <= widx_d;
      seed_q <= seed_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    w0_q <= w0_d;
    w1_q <= w1_d;
    z_q <= z_d;
    min_q <= min_d;
    span_q <= span_d;
    prob_q <= prob_d;
    draw_q <= draw_d;
    base_q <= base_d;
    remv_q <= remv_d;
    res_raw_q <= res_raw_d;
    res_val_q <= res_val_d;
    res_hit_q <= res_hit_d;
    if (load_out) begin
      out_raw_q <= res_raw_q;
      out_val_q <= res_val_q;
      out_hit_q <= res_hit_q;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.raw_word = out_raw_q;
  assign rsp_o.ranged_value = out_val_q;
  assign rsp_o.hit = out_hit_q;

  xbr_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  // The remainder unit loads the fresh draw at the edge that starts it.
  xbr_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (draw_sum),
    .divisor_i  (span_q),
    .done_o     (rem_done),
    .rem_o      (rem_val)
  );

`ifndef SYNTHESIS
  // The generator state never collapses to all zeros between items.
  a_state_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (w0_q != '0 || w1_q != '0))
    else $error("generator state is all zeros");

  a_rem_below_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_done |-> (rem_val < span_q))
    else $error("remainder not below span");

  a_mul_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == ST_MUL1 || state_q == ST_MUL2))
    else $error("multiplier finished outside a mix step");

  a_chance_needs_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHANCE) |-> (prob_q != '0))
    else $error("chance draw with zero probability");
`endif

endmodule

`default_nettype wire

/* bench/xbr_draw_checker.sv */
`timescale 1ns / 1ps

module xbr_draw_checker import xbr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  xbr_req_if   req_i,
  xbr_rsp_if   rsp_i,
  output int   pending_o,
  output int   fail_count_o
);

  localparam logic [WordW-1:0] AllOnes = '1;
  localparam logic [ProbW-1:0] ProbOne = ProbW'(1) << FracW;

  typedef struct packed {
    logic [WordW-1:0]         raw_word;
    logic signed [BoundW-1:0] ranged_value;
    logic                     hit;
  } draw_result_t;

  logic [WordW-1:0] gen_lo;
  logic [WordW-1:0] gen_hi;
  draw_result_t     expected_draws[$];
  draw_result_t     seen;
  draw_result_t     oldest;
  int               mismatches;

  function automatic logic [WordW-1:0] splitmix_mix(input logic [WordW-1:0] z);
    z = (z ^ (z >> MixShA)) * MixOne;
    z = (z ^ (z >> MixShB)) * MixTwo;
    return z ^ (z >> MixShC);
  endfunction

  function automatic logic [WordW-1:0] rotate_left(input logic [WordW-1:0] x, input int n);
    return (x << n) | (x >> (WordW - n));
  endfunction

  task automatic reseed_state(input logic [WordW-1:0] seed);
    seed = seed + GoldenStep;
    gen_lo = splitmix_mix(seed);
    seed = seed + GoldenStep;
    gen_hi = splitmix_mix(seed);
    if (gen_lo == '0 && gen_hi == '0) begin
      gen_lo = NonzeroFill;
    end
  endtask

  function automatic logic [WordW-1:0] next_draw();
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] sum;
    a = gen_lo;
    b = gen_hi ^ gen_lo;
    sum = gen_lo + gen_hi;
    gen_lo = rotate_left(a, RotA) ^ b ^ (b << ShlB);
    gen_hi = rotate_left(b, RotC);
    return sum;
  endfunction

  // The span is formed in 64 bits so that a full 32-bit range cannot wrap.
  function automatic logic [BoundW-1:0] pick_in_range(input logic signed [BoundW-1:0] lo,
                                                      input logic signed [BoundW-1:0] hi);
    longint           diff;
    logic [WordW-1:0] span;
    logic [WordW-1:0] cap;
    logic [WordW-1:0] d;
    logic [WordW-1:0] rem;
    if (hi <= lo) begin
      return lo;
    end
    diff = longint'(hi) - longint'(lo);
    span = diff + 1;
    cap = AllOnes - (AllOnes % span);
    do begin
      d = next_draw();
    end while (d >= cap);
    rem = d % span;
    return lo + rem[BoundW-1:0];
  endfunction

  function automatic logic chance_hit(input logic [ProbW-1:0] p);
    logic [WordW-1:0] top_bits;
    if (p == '0) begin
      return 1'b0;
    end
    if (p >= ProbOne) begin
      return 1'b1;
    end
    top_bits = next_draw() >> (WordW - FracW);
    return top_bits < WordW'(p);
  endfunction

  task automatic predict_item(input op_e op, input logic [WordW-1:0] seed,
                              input logic signed [BoundW-1:0] lo,
                              input logic signed [BoundW-1:0] hi,
                              input logic [ProbW-1:0] prob);
    draw_result_t want;
    want = '0;
    case (op)
      OP_RESEED: begin
        reseed_state(seed);
        return;
      end
      OP_RAW: want.raw_word = next_draw();
      OP_UNIFORM: want.ranged_value = pick_in_range(lo, hi);
      default: want.hit = chance_hit(prob);
    endcase
    expected_draws.push_back(want);
  endtask

  task automatic report(input string what, input logic [WordW-1:0] want,
                        input logic [WordW-1:0] got);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    mismatches++;
  endtask

  // Results are taken before requests, since a result never belongs to an item
  // accepted at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reseed_state('0);
      expected_draws.delete();
      mismatches = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        seen.raw_word = rsp_i.raw_word;
        seen.ranged_value = rsp_i.ranged_value;
        seen.hit = rsp_i.hit;
        if (expected_draws.size() == 0) begin
          report("unexpected result", '0, seen.raw_word);
        end else begin
          oldest = expected_draws.pop_front();
          if (seen.raw_word !== oldest.raw_word) begin
            report("raw_word", oldest.raw_word, seen.raw_word);
          end
          if (seen.ranged_value !== oldest.ranged_value) begin
            report("ranged_value", WordW'(oldest.ranged_value), WordW'(seen.ranged_value));
          end
          if (seen.hit !== oldest.hit) begin
            report("hit", WordW'(oldest.hit), WordW'(seen.hit));
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        predict_item(op_e'(req_i.operation), req_i.seed, req_i.range_min, req_i.range_max,
                     req_i.probability);
      end
    end
    pending_o <= expected_draws.size();
    fail_count_o <= mismatches;
  end

endmodule

/* bench/tb_xoroshiro_bounded_random.sv */
`timescale 1ns / 1ps

module tb_xoroshiro_bounded_random;
  import xbr_pkg::*;

  localparam int HalfPeriod = 4;
  localparam int ResetCycles = 9;
  localparam int RandomItems = 1500;
  localparam int Phases = 4;
  localparam int MaxGap = 16;
  localparam int DrainCycles = 200;
  localparam int IdleLimit = 5000;

  localparam logic signed [BoundW-1:0] BoundLow = 32'sh8000_0000;
  localparam logic signed [BoundW-1:0] BoundHigh = 32'sh7FFF_FFFF;
  localparam logic [ProbW-1:0] ProbOne = ProbW'(1) << FracW;
  localparam logic [ProbW-1:0] ProbAll = '1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   pending_draws;
  int   draw_failures;
  int   send_gap_max = MaxGap;
  int   take_gap_max = MaxGap;
  int   idle_cycles = 0;

  xbr_req_if req_bus ();
  xbr_rsp_if rsp_bus ();

  xoroshiro_bounded_random dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  xbr_draw_checker draw_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_bus),
    .rsp_i       (rsp_bus),
    .pending_o   (pending_draws),
    .fail_count_o(draw_failures)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  // Fields that the operation ignores carry random noise.
  task automatic send(input op_e op, input logic [WordW-1:0] seed,
                      input logic signed [BoundW-1:0] lo,
                      input logic signed [BoundW-1:0] hi,
                      input logic [ProbW-1:0] prob);
    int gap;
    gap = $urandom_range(send_gap_max, 0);
    if (gap != 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid <= 1'b1;
    req_bus.operation <= op;
    req_bus.seed <= (op == OP_RESEED) ? seed : {$urandom, $urandom};
    req_bus.range_min <= (op == OP_UNIFORM) ? lo : $urandom;
    req_bus.range_max <= (op == OP_UNIFORM) ? hi : $urandom;
    req_bus.probability <= (op == OP_CHANCE) ? prob : ProbW'({$urandom, $urandom});
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
  endtask

  task automatic hold_until_drained();
    req_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_draws != 0) @(posedge clk_i);
  endtask

  task automatic random_item();
    int                       pick;
    op_e                      op;
    logic signed [BoundW-1:0] lo;
    logic signed [BoundW-1:0] hi;
    logic [ProbW-1:0]         prob;
    pick = $urandom_range(99, 0);
    if (pick < 10) begin
      op = OP_RESEED;
    end else if (pick < 35) begin
      op = OP_RAW;
    end else if (pick < 70) begin
      op = OP_UNIFORM;
    end else begin
      op = OP_CHANCE;
    end
    lo = $urandom;
    case ($urandom_range(4, 0))
      0: hi = $urandom;
      1: hi = lo + $urandom_range(15, 0);
      2: begin
        lo = BoundLow + $urandom_range(3, 0);
        hi = BoundHigh - $urandom_range(3, 0);
      end
      3: hi = lo - $urandom_range(2, 0);
      default: begin
        lo = -$urandom_range(8, 0);
        hi = $urandom_range(8, 0);
      end
    endcase
    case ($urandom_range(9, 0))
      0: prob = '0;
      1: prob = ProbOne | ProbW'({$urandom, $urandom});
      2: prob = ProbW'($urandom_range(3, 1));
      3: prob = ProbOne - ProbW'($urandom_range(3, 1));
      default: prob = ProbW'(FracW'({$urandom, $urandom}));
    endcase
    send(op, {$urandom, $urandom}, lo, hi, prob);
  endtask

  initial begin
    req_bus.valid <= 1'b0;
    req_bus.operation <= OP_RAW;
    req_bus.seed <= '0;
    req_bus.range_min <= '0;
    req_bus.range_max <= '0;
    req_bus.probability <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The first draw comes from the state that reset seeds with zero.
    send(OP_RAW, '0, '0, '0, '0);
    send(OP_RESEED, '0, '0, '0, '0);
    send(OP_RAW, '0, '0, '0, '0);
    send(OP_RESEED, '1, '0, '0, '0);
    send(OP_RAW, '0, '0, '0, '0);
    // Seeds that make one of the two words come out zero.
    send(OP_RESEED, -GoldenStep, '0, '0, '0);
    send(OP_RAW, '0, '0, '0, '0);
    send(OP_RESEED, -(GoldenStep << 1), '0, '0, '0);
    send(OP_RAW, '0, '0, '0, '0);
    send(OP_UNIFORM, '0, 32'sd5, 32'sd5, '0);
    send(OP_UNIFORM, '0, 32'sd7, -32'sd3, '0);
    send(OP_UNIFORM, '0, BoundHigh, BoundLow, '0);
    send(OP_UNIFORM, '0, BoundLow, BoundHigh, '0);
    send(OP_UNIFORM, '0, BoundLow, BoundLow + 1, '0);
    send(OP_UNIFORM, '0, BoundHigh - 1, BoundHigh, '0);
    send(OP_UNIFORM, '0, -32'sd1, 32'sd0, '0);
    send(OP_UNIFORM, '0, 32'sd0, 32'sd2, '0);
    send(OP_CHANCE, '0, '0, '0, '0);
    send(OP_CHANCE, '0, '0, '0, ProbOne);
    send(OP_CHANCE, '0, '0, '0, ProbAll);
    send(OP_CHANCE, '0, '0, '0, ProbW'(1));
    send(OP_CHANCE, '0, '0, '0, ProbOne - 1);
    send(OP_CHANCE, '0, '0, '0, ProbOne >> 1);
    send(OP_RAW, '0, '0, '0, '0);
    hold_until_drained();

    // Each phase sets its own idling on both sides; the sender then waits for
    // every result before the next phase starts.
    for (int phase = 0; phase < Phases; phase++) begin
      send_gap_max = phase[0] ? 0 : MaxGap;
      take_gap_max <= phase[1] ? 0 : MaxGap;
      for (int n = 0; n < RandomItems / Phases; n++) begin
        random_item();
      end
      hold_until_drained();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (draw_failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : take_side
    int gap;
    rsp_bus.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      gap = $urandom_range(take_gap_max, 0);
      if (gap != 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_bus.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_bus.valid) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IdleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
